FILE: src/pap_pkg.sv
// ----------------------------------------------------------------------------
// pap_pkg
// Shared codes and the cell control bundle of the positional array.
// ----------------------------------------------------------------------------
package pap_pkg;

  localparam int WORD_W   = 32;
  localparam int POS_W    = 6;
  localparam int STATUS_W = 3;
  localparam int INDEX_W  = 5;

  localparam logic [1:0] OP_INSERT   = 2'd0;
  localparam logic [1:0] OP_DELETE   = 2'd1;
  localparam logic [1:0] OP_SEARCH   = 2'd2;
  localparam logic [1:0] OP_TRAVERSE = 2'd3;

  localparam logic [STATUS_W-1:0] STAT_DONE     = 3'd0;
  localparam logic [STATUS_W-1:0] STAT_FOUND    = 3'd1;
  localparam logic [STATUS_W-1:0] STAT_NOTFOUND = 3'd2;
  localparam logic [STATUS_W-1:0] STAT_BADPOS   = 3'd3;
  localparam logic [STATUS_W-1:0] STAT_FULL     = 3'd4;
  localparam logic [STATUS_W-1:0] STAT_EMPTY    = 3'd5;

  localparam logic [1:0] MODE_HOLD   = 2'd0;
  localparam logic [1:0] MODE_INSERT = 2'd1;
  localparam logic [1:0] MODE_DELETE = 2'd2;
  localparam logic [1:0] MODE_ROTATE = 2'd3;

  // pos is the insert or delete position, or the top occupied cell on a rotate
  typedef struct packed {
    logic [1:0]        mode;
    logic [POS_W-1:0]  pos;
    logic [WORD_W-1:0] value;
  } cell_ctrl_t;

endpackage

FILE: src/pap_cell.sv
// ----------------------------------------------------------------------------
// pap_cell
// One word of the array; shifts up, shifts down or rotates with its neighbours.
// ----------------------------------------------------------------------------
module pap_cell #(
  parameter int IDX = 0
) (
  input  logic                        clk,
  input  pap_pkg::cell_ctrl_t         ctrl,
  input  logic [pap_pkg::WORD_W-1:0]  lower,
  input  logic [pap_pkg::WORD_W-1:0]  upper,
  input  logic [pap_pkg::WORD_W-1:0]  wrap,
  output logic [pap_pkg::WORD_W-1:0]  word
);

  localparam logic [pap_pkg::POS_W-1:0] ID = pap_pkg::POS_W'(IDX);

  logic [pap_pkg::WORD_W-1:0] word_next;

  always_comb begin
    word_next = word;
    unique case (ctrl.mode)
      pap_pkg::MODE_INSERT: begin
        if (ID > ctrl.pos) begin
          word_next = lower;
        end else if (ID == ctrl.pos) begin
          word_next = ctrl.value;
        end
      end
      pap_pkg::MODE_DELETE: begin
        if (ID >= ctrl.pos) begin
          word_next = upper;
        end
      end
      pap_pkg::MODE_ROTATE: begin
        if (ID == ctrl.pos) begin
          word_next = wrap;
        end else begin
          word_next = upper;
        end
      end
      default: begin
        word_next = word;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    word <= word_next;
  end

endmodule

FILE: src/positional_array_insert_delete_search.sv
// ----------------------------------------------------------------------------
// positional_array_insert_delete_search
// Packed array of signed words in a chain of cells with insert, delete,
// search and traverse.
// ----------------------------------------------------------------------------
// Insert and delete load every cell at and above the position at once, from
// its neighbour or the new value. Search and traverse rotate the chain, one
// stored word passing cell 0 per cycle while the result register is free, and
// traverse emits one result per cycle as the sink takes them; both leave the
// order as it was. A new request is taken once the previous one is finished
// and the result register is free or being emptied.
module positional_array_insert_delete_search #(
  parameter int DEPTH = 32
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               req_valid,
  output logic                               req_stall,
  input  logic [1:0]                         op,
  input  logic signed [pap_pkg::WORD_W-1:0]  value,
  input  logic [pap_pkg::POS_W-1:0]          position,
  output logic                               res_valid,
  input  logic                               res_stall,
  output logic [pap_pkg::STATUS_W-1:0]       status,
  output logic [pap_pkg::INDEX_W-1:0]        index,
  output logic signed [pap_pkg::WORD_W-1:0]  word,
  output logic                               last
);

  localparam int CW   = $clog2(DEPTH + 1);
  localparam int KW   = $clog2(DEPTH);
  localparam int CMPW = (CW > pap_pkg::POS_W) ? CW : pap_pkg::POS_W;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_TRAV = 2'd1;
  localparam logic [1:0] ST_SRCH = 2'd2;

  logic [1:0]                  state, state_next;
  logic [CW-1:0]               count, count_next;
  logic [KW-1:0]               step, step_next;
  logic [pap_pkg::WORD_W-1:0]  key, key_next;
  logic                        hit, hit_next;
  logic [KW-1:0]               hit_idx, hit_idx_next;

  logic                            load_out;
  logic [pap_pkg::STATUS_W-1:0]    out_status;
  logic [pap_pkg::INDEX_W-1:0]     out_index;
  logic [pap_pkg::WORD_W-1:0]      out_word;
  logic                            out_last;

  pap_pkg::cell_ctrl_t         ctrl;
  logic [pap_pkg::WORD_W-1:0]  cell_word [DEPTH];

  logic out_free, accept, empty, full, at_end, match;
  logic [CMPW-1:0] pos_ext, cnt_ext;

  assign out_free  = !res_valid || !res_stall;
  assign req_stall = (state != ST_IDLE) || !out_free;
  assign accept    = req_valid && !req_stall;
  assign empty     = (count == '0);
  assign full      = (count == CW'(DEPTH));
  assign pos_ext   = CMPW'(position);
  assign cnt_ext   = CMPW'(count);
  assign at_end    = (CW'(step) == count - 1'b1);
  assign match     = (cell_word[0] == key);

  always_comb begin
    state_next   = state;
    count_next   = count;
    step_next    = step;
    key_next     = key;
    hit_next     = hit;
    hit_idx_next = hit_idx;
    load_out     = 1'b0;
    out_status   = pap_pkg::STAT_DONE;
    out_index    = '0;
    out_word     = '0;
    out_last     = 1'b1;
    ctrl.mode    = pap_pkg::MODE_HOLD;
    ctrl.pos     = position;
    ctrl.value   = value;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          unique case (op)
            pap_pkg::OP_INSERT: begin
              load_out = 1'b1;
              if (full) begin
                out_status = pap_pkg::STAT_FULL;
              end else if (pos_ext > cnt_ext) begin
                out_status = pap_pkg::STAT_BADPOS;
              end else begin
                ctrl.mode  = pap_pkg::MODE_INSERT;
                count_next = count + 1'b1;
              end
            end
            pap_pkg::OP_DELETE: begin
              load_out = 1'b1;
              if (empty) begin
                out_status = pap_pkg::STAT_EMPTY;
              end else if (pos_ext >= cnt_ext) begin
                out_status = pap_pkg::STAT_BADPOS;
              end else begin
                ctrl.mode  = pap_pkg::MODE_DELETE;
                count_next = count - 1'b1;
              end
            end
            pap_pkg::OP_SEARCH: begin
              if (empty) begin
                load_out   = 1'b1;
                out_status = pap_pkg::STAT_NOTFOUND;
              end else begin
                state_next = ST_SRCH;
                step_next  = '0;
                hit_next   = 1'b0;
                key_next   = value;
              end
            end
            default: begin
              if (empty) begin
                load_out   = 1'b1;
                out_status = pap_pkg::STAT_EMPTY;
              end else begin
                state_next = ST_TRAV;
                step_next  = '0;
              end
            end
          endcase
        end
      end
      ST_TRAV: begin
        if (out_free) begin
          ctrl.mode  = pap_pkg::MODE_ROTATE;
          ctrl.pos   = pap_pkg::POS_W'(count - 1'b1);
          load_out   = 1'b1;
          out_index  = pap_pkg::INDEX_W'(step);
          out_word   = cell_word[0];
          out_last   = at_end;
          step_next  = step + 1'b1;
          if (at_end) begin
            state_next = ST_IDLE;
          end
        end
      end
      ST_SRCH: begin
        if (out_free) begin
          ctrl.mode = pap_pkg::MODE_ROTATE;
          ctrl.pos  = pap_pkg::POS_W'(count - 1'b1);
          step_next = step + 1'b1;
          if (match && !hit) begin
            hit_next     = 1'b1;
            hit_idx_next = step;
          end
          if (at_end) begin
            state_next = ST_IDLE;
            load_out   = 1'b1;
            if (hit) begin
              out_status = pap_pkg::STAT_FOUND;
              out_index  = pap_pkg::INDEX_W'(hit_idx);
            end else if (match) begin
              out_status = pap_pkg::STAT_FOUND;
              out_index  = pap_pkg::INDEX_W'(step);
            end else begin
              out_status = pap_pkg::STAT_NOTFOUND;
            end
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      count     <= '0;
      res_valid <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      if (load_out) begin
        res_valid <= 1'b1;
      end else if (!res_stall) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    step    <= step_next;
    key     <= key_next;
    hit     <= hit_next;
    hit_idx <= hit_idx_next;
    if (load_out) begin
      status <= out_status;
      index  <= out_index;
      word   <= out_word;
      last   <= out_last;
    end
  end

  // chain of cells
  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    logic [pap_pkg::WORD_W-1:0] lower_w, upper_w;
    if (g == 0) begin : g_bottom
      assign lower_w = '0;
    end else begin : g_below
      assign lower_w = cell_word[g-1];
    end
    if (g == DEPTH - 1) begin : g_top
      assign upper_w = '0;
    end else begin : g_above
      assign upper_w = cell_word[g+1];
    end
    pap_cell #(
      .IDX(g)
    ) u_cell (
      .clk   (clk),
      .ctrl  (ctrl),
      .lower (lower_w),
      .upper (upper_w),
      .wrap  (cell_word[0]),
      .word  (cell_word[g])
    );
  end

endmodule

FILE: tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the positional array. A driver feeds insert,
// delete, search and traverse requests from a queue, a shadow copy of the
// array predicts every result, and a monitor compares the results field by
// field as they are taken, under random idling, a long sink hold-off and
// pauses in which the source waits for the array to drain.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int DEPTH       = 32;
  localparam int HOLD_AT     = 130;
  localparam int HOLD_LEN    = 150;
  localparam int QUIET_LIMIT = 2000;
  localparam int TAIL_CYCLES = 40;

  typedef struct {
    logic                              pause;
    logic [1:0]                        op;
    logic signed [pap_pkg::WORD_W-1:0] value;
    logic [pap_pkg::POS_W-1:0]         position;
  } array_req_t;

  typedef struct {
    logic [pap_pkg::STATUS_W-1:0]      status;
    logic [pap_pkg::INDEX_W-1:0]       index;
    logic signed [pap_pkg::WORD_W-1:0] word;
    logic                              last;
  } array_res_t;

  logic                              clk       = 1'b0;
  logic                              rst       = 1'b1;
  logic                              req_valid = 1'b0;
  logic                              req_stall;
  logic [1:0]                        op        = pap_pkg::OP_INSERT;
  logic signed [pap_pkg::WORD_W-1:0] value     = '0;
  logic [pap_pkg::POS_W-1:0]         position  = '0;
  logic                              res_valid;
  logic                              res_stall = 1'b0;
  logic [pap_pkg::STATUS_W-1:0]      status;
  logic [pap_pkg::INDEX_W-1:0]       index;
  logic signed [pap_pkg::WORD_W-1:0] word;
  logic                              last;

  array_req_t                        pending_reqs[$];
  array_res_t                        expected_res[$];
  logic signed [pap_pkg::WORD_W-1:0] gen_words[$];
  logic signed [pap_pkg::WORD_W-1:0] model_words[DEPTH];
  int unsigned                       model_count = 0;

  array_req_t  next_req;
  array_res_t  want;
  int unsigned accepted_reqs   = 0;
  int unsigned results_checked = 0;
  int unsigned results_owed    = 0;
  int unsigned traverse_reqs   = 0;
  int unsigned peak_fill       = 0;
  int unsigned mismatches      = 0;
  int unsigned quiet_cycles    = 0;
  int unsigned hold_cycles     = 0;
  logic        hold_done       = 1'b0;
  logic        all_sent        = 1'b0;
  logic        calm;

  assign calm = (accepted_reqs >= 30) && (accepted_reqs < 90);

  positional_array_insert_delete_search #(
    .DEPTH(DEPTH)
  ) u_dut (
    .clk      (clk),
    .rst      (rst),
    .req_valid(req_valid),
    .req_stall(req_stall),
    .op       (op),
    .value    (value),
    .position (position),
    .res_valid(res_valid),
    .res_stall(res_stall),
    .status   (status),
    .index    (index),
    .word     (word),
    .last     (last)
  );

  always #4 clk = ~clk;

  // shadow array: updates the stored words and queues the results of one request
  task automatic apply_to_model(input logic [1:0] kind,
                                input logic signed [pap_pkg::WORD_W-1:0] v,
                                input logic [pap_pkg::POS_W-1:0] pos);
    array_res_t  r;
    int unsigned i;
    logic        hit;
    r = '{status: pap_pkg::STAT_DONE, index: '0, word: '0, last: 1'b1};
    hit = 1'b0;
    case (kind)
      pap_pkg::OP_INSERT: begin
        if (model_count >= DEPTH) begin
          r.status = pap_pkg::STAT_FULL;
        end else if (pos > model_count) begin
          r.status = pap_pkg::STAT_BADPOS;
        end else begin
          for (i = model_count; i > pos; i--) model_words[i] = model_words[i-1];
          model_words[pos] = v;
          model_count++;
          if (model_count > peak_fill) peak_fill = model_count;
        end
        expected_res.push_back(r);
      end
      pap_pkg::OP_DELETE: begin
        if (model_count == 0) begin
          r.status = pap_pkg::STAT_EMPTY;
        end else if (pos >= model_count) begin
          r.status = pap_pkg::STAT_BADPOS;
        end else begin
          for (i = pos; i + 1 < model_count; i++) model_words[i] = model_words[i+1];
          model_count--;
        end
        expected_res.push_back(r);
      end
      pap_pkg::OP_SEARCH: begin
        r.status = pap_pkg::STAT_NOTFOUND;
        for (i = 0; i < model_count; i++) begin
          if (!hit && model_words[i] == v) begin
            hit = 1'b1;
            r.status = pap_pkg::STAT_FOUND;
            r.index = pap_pkg::INDEX_W'(i);
          end
        end
        expected_res.push_back(r);
      end
      default: begin
        traverse_reqs++;
        if (model_count == 0) begin
          r.status = pap_pkg::STAT_EMPTY;
          expected_res.push_back(r);
        end else begin
          for (i = 0; i < model_count; i++) begin
            r.index = pap_pkg::INDEX_W'(i);
            r.word = model_words[i];
            r.last = (i + 1 == model_count);
            expected_res.push_back(r);
          end
        end
      end
    endcase
  endtask

  task automatic note_mismatch(input string what, input array_res_t exp_res);
    mismatches++;
    if (mismatches <= 10)
      $display("%s: expected status %0d index %0d word %0d last %0d, got %0d %0d %0d %0d",
               what, exp_res.status, exp_res.index, exp_res.word, exp_res.last,
               status, index, word, last);
  endtask

  function automatic logic signed [pap_pkg::WORD_W-1:0] rand_word();
    case ($urandom_range(0, 9))
      0:       return 32'sh7FFF_FFFF;
      1:       return 32'sh8000_0000;
      2, 3, 4: return pap_pkg::WORD_W'($urandom_range(0, 7)) - 3;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic signed [pap_pkg::WORD_W-1:0] pick_search();
    if (gen_words.size() != 0 && $urandom_range(0, 2) != 0)
      return gen_words[$urandom_range(0, gen_words.size() - 1)];
    return rand_word();
  endfunction

  task automatic queue_req(input logic [1:0] kind,
                           input logic signed [pap_pkg::WORD_W-1:0] v,
                           input logic [pap_pkg::POS_W-1:0] pos);
    array_req_t r;
    r = '{pause: 1'b0, op: kind, value: v, position: pos};
    pending_reqs.push_back(r);
    if (kind == pap_pkg::OP_INSERT && gen_words.size() < DEPTH && pos <= gen_words.size())
      gen_words.insert(pos, v);
    else if (kind == pap_pkg::OP_DELETE && pos < gen_words.size())
      gen_words.delete(pos);
  endtask

  task automatic queue_pause();
    array_req_t r;
    r = '{pause: 1'b1, op: pap_pkg::OP_INSERT, value: '0, position: '0};
    pending_reqs.push_back(r);
  endtask

  task automatic queue_random(input int unsigned count, input int unsigned insert_pct);
    int unsigned n;
    int unsigned roll;
    int unsigned sz;
    for (n = 0; n < count; n++) begin
      roll = $urandom_range(0, 99);
      sz = gen_words.size();
      if (roll < 12)
        queue_req(2'($urandom_range(0, 3)), rand_word(),
                  pap_pkg::POS_W'($urandom_range(0, 63)));
      else if (roll < 12 + insert_pct)
        queue_req(pap_pkg::OP_INSERT, rand_word(), pap_pkg::POS_W'($urandom_range(0, sz)));
      else if (roll < 32 + insert_pct)
        queue_req(pap_pkg::OP_DELETE, rand_word(),
                  pap_pkg::POS_W'($urandom_range(0, (sz == 0) ? 0 : sz - 1)));
      else if (roll < 90)
        queue_req(pap_pkg::OP_SEARCH, pick_search(), pap_pkg::POS_W'($urandom));
      else
        queue_req(pap_pkg::OP_TRAVERSE, rand_word(), pap_pkg::POS_W'($urandom));
    end
  endtask

  initial begin
    // empty array corner cases
    queue_req(pap_pkg::OP_TRAVERSE, 0, 0);
    queue_req(pap_pkg::OP_SEARCH, 0, 0);
    queue_req(pap_pkg::OP_DELETE, 0, 0);
    queue_req(pap_pkg::OP_DELETE, 0, 63);
    queue_req(pap_pkg::OP_INSERT, 5, 1);
    // build, with extremes, head, tail and middle inserts and a duplicate
    queue_req(pap_pkg::OP_INSERT, 32'sh7FFF_FFFF, 0);
    queue_req(pap_pkg::OP_INSERT, 32'sh8000_0000, 0);
    queue_req(pap_pkg::OP_INSERT, -1, 2);
    queue_req(pap_pkg::OP_INSERT, 0, 1);
    queue_req(pap_pkg::OP_INSERT, 0, 4);
    queue_req(pap_pkg::OP_SEARCH, 0, 0);
    queue_req(pap_pkg::OP_SEARCH, 32'sh8000_0000, 0);
    queue_req(pap_pkg::OP_SEARCH, 12345, 0);
    queue_req(pap_pkg::OP_INSERT, 9, 6);
    queue_req(pap_pkg::OP_INSERT, 9, 63);
    queue_req(pap_pkg::OP_DELETE, 0, 5);
    queue_req(pap_pkg::OP_DELETE, 0, 32);
    queue_req(pap_pkg::OP_TRAVERSE, 0, 0);
    queue_req(pap_pkg::OP_DELETE, 0, 0);
    queue_req(pap_pkg::OP_DELETE, 0, 3);
    queue_req(pap_pkg::OP_DELETE, 0, 1);
    queue_req(pap_pkg::OP_TRAVERSE, 0, 0);
    queue_pause();
    queue_random(60, 45);
    queue_pause();
    // fill to the top, exercise the full array, then empty it again
    while (gen_words.size() < DEPTH)
      queue_req(pap_pkg::OP_INSERT, rand_word(),
                pap_pkg::POS_W'($urandom_range(0, gen_words.size())));
    queue_req(pap_pkg::OP_INSERT, rand_word(), 0);
    queue_req(pap_pkg::OP_INSERT, rand_word(), 40);
    queue_req(pap_pkg::OP_SEARCH, pick_search(), 0);
    queue_req(pap_pkg::OP_SEARCH, rand_word(), 0);
    queue_req(pap_pkg::OP_TRAVERSE, 0, 0);
    queue_req(pap_pkg::OP_DELETE, 0, 32);
    while (gen_words.size() != 0) begin
      if ($urandom_range(0, 7) == 0) queue_req(pap_pkg::OP_SEARCH, pick_search(), 0);
      queue_req(pap_pkg::OP_DELETE, 0,
                pap_pkg::POS_W'($urandom_range(0, gen_words.size() - 1)));
    end
    queue_req(pap_pkg::OP_TRAVERSE, 0, 0);
    queue_pause();
    queue_random(80, 30);
    queue_pause();

    repeat (5) @(posedge clk);
    rst <= 1'b0;
    while (!all_sent) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    $display("ran %0d requests including %0d traverses, checked %0d results",
             accepted_reqs, traverse_reqs, results_checked);
    $display("array fill reached %0d of %0d words, %0d mismatches",
             peak_fill, DEPTH, mismatches);
    if (mismatches == 0 && expected_res.size() == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

  // request driver
  always @(posedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
    end else if (!req_valid || !req_stall) begin
      if (pending_reqs.size() == 0) begin
        req_valid <= 1'b0;
        all_sent <= 1'b1;
      end else if (pending_reqs[0].pause) begin
        req_valid <= 1'b0;
        if (!req_valid && results_owed == 0) void'(pending_reqs.pop_front());
      end else if (!calm && $urandom_range(0, 99) < 11) begin
        req_valid <= 1'b0;
      end else begin
        next_req = pending_reqs.pop_front();
        req_valid <= 1'b1;
        op <= next_req.op;
        value <= next_req.value;
        position <= next_req.position;
      end
    end
  end

  // result sink with one long hold-off
  always @(posedge clk) begin
    if (rst) begin
      res_stall <= 1'b0;
    end else if (hold_cycles != 0) begin
      hold_cycles <= hold_cycles - 1;
      res_stall <= 1'b1;
    end else if (!hold_done && accepted_reqs >= HOLD_AT) begin
      hold_done <= 1'b1;
      hold_cycles <= HOLD_LEN;
      res_stall <= 1'b1;
    end else begin
      res_stall <= !calm && ($urandom_range(0, 99) < 11);
    end
  end

  // monitor: check results first, then predict the request taken at this edge
  always @(posedge clk) begin
    if (!rst) begin
      if (res_valid && !res_stall) begin
        results_checked <= results_checked + 1;
        if (expected_res.size() == 0) begin
          note_mismatch("result with nothing pending", '{default: '0});
        end else begin
          want = expected_res.pop_front();
          if (status !== want.status || index !== want.index || word !== want.word ||
              last !== want.last)
            note_mismatch("result mismatch", want);
        end
      end
      if (req_valid && !req_stall) begin
        accepted_reqs <= accepted_reqs + 1;
        apply_to_model(op, value, position);
      end
      results_owed <= expected_res.size();
    end
  end

  always @(posedge clk) begin
    if (rst || (req_valid && !req_stall) || (res_valid && !res_stall))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles == QUIET_LIMIT) begin
      $display("timeout: no handshake for %0d cycles", QUIET_LIMIT);
      $display("Some tests failed");
      $finish;
    end
  end

endmodule

FILE: sim.f
src/pap_pkg.sv
src/pap_cell.sv
src/positional_array_insert_delete_search.sv
tb/tb_top.sv
